// ===== sv/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_POS  = 3'd2,
    ACT_DEL_HEAD = 3'd3,
    ACT_DEL_TAIL = 3'd4,
    ACT_DEL_POS  = 3'd5,
    ACT_TRAVERSE = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // per-cell next-value select
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_HEAD  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic busy;
    logic full;
    logic empty;
  } ple_stat_t;

endpackage : ple_pkg
`default_nettype wire

// ===== sv/ple_if.sv =====
// Command and result channel interfaces for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
interface ple_in_if
  import ple_pkg::*;
();
  logic                    valid;
  logic                    ready;
  action_t                 action;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink   (input valid, input action, input value, input position, output ready);
endinterface : ple_in_if

interface ple_out_if
  import ple_pkg::*;
();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] element;
  logic [IDX_W-1:0]        element_index;
  logic                    last;

  modport source (output valid, output status, output element, output element_index,
                  output last, input ready);
  modport sink   (input valid, input status, input element, input element_index,
                  input last, output ready);
endinterface : ple_out_if
`default_nettype wire

// ===== sv/ple_cell.sv =====
// One storage cell of the list chain: holds, loads, or takes a neighbour's or the head cell's value.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell
  import ple_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_op_t                op,
  input  wire logic signed [VAL_W-1:0] load_val,
  input  wire logic signed [VAL_W-1:0] left_val,
  input  wire logic signed [VAL_W-1:0] right_val,
  input  wire logic signed [VAL_W-1:0] head_val,
  output logic signed [VAL_W-1:0]      q
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    unique case (op)
      OP_LOAD:  val_nxt = load_val;
      OP_LEFT:  val_nxt = left_val;
      OP_RIGHT: val_nxt = right_val;
      OP_HEAD:  val_nxt = head_val;
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule : ple_cell
`default_nettype wire

// ===== sv/ple_ctrl.sv =====
// Command decode, entry count, traverse sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  ple_in_if.sink                       in_ch,
  ple_out_if.source                    out_ch,
  input  wire logic signed [VAL_W-1:0] head_val,
  output cell_op_t [DEPTH-1:0]         ops,
  output ple_stat_t                    stat
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [PW-1:0]           step_r, step_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_elem_r, out_elem_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    out_free, in_fire, full, empty;
  logic                    is_ins, is_del, load_out;
  logic [PW-1:0]           cnt_x, pos_x, p;

  assign cnt_x    = PW'(cnt_r);
  assign pos_x    = PW'(in_ch.position);
  assign full     = (cnt_x == PW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    p      = '0;
    unique case (in_ch.action)
      ACT_INS_HEAD: begin is_ins = 1'b1; p = '0; end
      ACT_INS_TAIL: begin is_ins = 1'b1; p = cnt_x; end
      ACT_INS_POS:  begin is_ins = 1'b1; p = pos_x; end
      ACT_DEL_HEAD: begin is_del = 1'b1; p = '0; end
      ACT_DEL_TAIL: begin is_del = 1'b1; p = cnt_x - PW'(1); end
      ACT_DEL_POS:  begin is_del = 1'b1; p = pos_x; end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    load_out       = 1'b0;
    out_status_nxt = ST_OK;
    out_elem_nxt   = '0;
    out_idx_nxt    = '0;
    out_last_nxt   = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = OP_HOLD;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          if (is_ins) begin
            if (full) begin
              out_status_nxt = ST_FULL;
            end else if (p > cnt_x) begin
              out_status_nxt = ST_RANGE;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
              for (int i = 0; i < DEPTH; i++) begin
                if (PW'(i) == p) begin
                  ops[i] = OP_LOAD;
                end else if (PW'(i) > p && PW'(i) <= cnt_x) begin
                  ops[i] = OP_LEFT;
                end
              end
            end
          end else if (is_del) begin
            if (empty) begin
              out_status_nxt = ST_EMPTY;
            end else if (p >= cnt_x) begin
              out_status_nxt = ST_RANGE;
            end else begin
              cnt_nxt = cnt_r - CW'(1);
              for (int i = 0; i < DEPTH; i++) begin
                if (PW'(i) >= p && PW'(i + 1) < cnt_x) begin
                  ops[i] = OP_RIGHT;
                end
              end
            end
          end else if (in_ch.action == ACT_TRAVERSE) begin
            if (empty) begin
              out_status_nxt = ST_EMPTY;
            end else begin
              load_out  = 1'b0;
              state_nxt = S_WALK;
              step_nxt  = '0;
            end
          end
        end
      end
      S_WALK: begin
        // rotate the occupied cells one place; the head is emitted on each of the first MAX_RESULTS steps
        if (step_r >= PW'(MAX_RESULTS) || out_free) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (PW'(i + 1) < cnt_x) begin
              ops[i] = OP_RIGHT;
            end else if (PW'(i + 1) == cnt_x) begin
              ops[i] = OP_HEAD;
            end
          end
          if (step_r < PW'(MAX_RESULTS)) begin
            load_out       = 1'b1;
            out_status_nxt = ST_OK;
            out_elem_nxt   = head_val;
            out_idx_nxt    = step_r[IDX_W-1:0];
            out_last_nxt   = (step_r + PW'(1) == cnt_x) ||
                             (step_r == PW'(MAX_RESULTS - 1));
          end
          step_nxt = step_r + PW'(1);
          if (step_r + PW'(1) == cnt_x) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_elem_r   <= out_elem_nxt;
      out_idx_r    <= out_idx_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.element       = out_elem_r;
  assign out_ch.element_index = out_idx_r;
  assign out_ch.last          = out_last_r;

  assign stat.busy  = (state_r == S_WALK);
  assign stat.full  = full;
  assign stat.empty = empty;

endmodule : ple_ctrl
`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// Positional list engine: ordered list of signed entries in a chain of shifting cells.
// Insert/delete: on acceptance, status result in the output register next cycle.
// Traverse: one result per cycle per entry (first 16) while the output is not stalled;
//   cells rotate one place per entry; input held off until the rotation completes.
// A new transaction is taken whenever idle and the output register is free or being drained.
// Synchronous active-low reset empties the list; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  cell_op_t [DEPTH-1:0]    ops;
  logic signed [VAL_W-1:0] q [DEPTH];
  ple_stat_t               stat;

  ple_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .head_val (q[0]),
    .ops      (ops),
    .stat     (stat)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ple_cell u_cell (
      .clk       (clk),
      .op        (ops[i]),
      .load_val  (in_ch.value),
      .left_val  ((i == 0) ? '0 : q[(i == 0) ? 0 : i - 1]),
      .right_val ((i == DEPTH - 1) ? '0 : q[(i == DEPTH - 1) ? i : i + 1]),
      .head_val  (q[0]),
      .q         (q[i])
    );
  end

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ch.ready)
    else $error("transaction accepted during traverse");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stat.full && (in_ch.action == ACT_INS_HEAD ||
      in_ch.action == ACT_INS_TAIL || in_ch.action == ACT_INS_POS)
    |=> out_ch.valid && out_ch.status == ST_FULL)
    else $error("insert into full list not reported");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && stat.empty && (in_ch.action == ACT_DEL_HEAD ||
      in_ch.action == ACT_DEL_TAIL || in_ch.action == ACT_DEL_POS)
    |=> out_ch.valid && out_ch.status == ST_EMPTY)
    else $error("delete from empty list not reported");

  a_fire_responds: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid || stat.busy)
    else $error("accepted transaction produced no result");

endmodule : positional_list_engine
`default_nettype wire
